### hdl/rgb_to_hsv_converter_defines.svh
// Assertion macros for the checker file.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Checked only while the block is out of reset.
`define RGBHSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RGBHSV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CHAN_W        = 8;
  // Six times the largest channel spread (6 * 255) fits in eleven bits.
  localparam int SPAN_W        = 11;
  localparam int IN_DATA_W     = 3 * CHAN_W;

  // Divider state handed from stage to stage.
  typedef struct packed {
    logic [CHAN_W-1:0] bright;  // largest channel, passed through
    logic [CHAN_W-1:0] hi_div;  // saturation divisor, never zero
    logic [CHAN_W-1:0] srem;    // saturation partial remainder, below hi_div
    logic [SPAN_W-1:0] span;    // hue divisor 6*delta, never zero
    logic [SPAN_W-1:0] hrem;    // hue partial remainder, below span
  } div_state_t;

endpackage

### hdl/rgbhsv_front.sv
module rgbhsv_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgbhsv_pkg::CHAN_W-1:0]     red,
  input  logic [rgbhsv_pkg::CHAN_W-1:0]     green,
  input  logic [rgbhsv_pkg::CHAN_W-1:0]     blue,
  output logic                              o_valid,
  input  logic                              o_ready,
  output rgbhsv_pkg::div_state_t            o_state,
  output logic                              o_sat_int
);
  import rgbhsv_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Stage 1: max, min and the winning channel.
  logic              v1_r;
  logic              rdy1;
  logic [CHAN_W-1:0] r1_r, g1_r, b1_r, hi1_r, lo1_r;
  sector_t           sec1_r;
  logic [CHAN_W-1:0] hi_nxt, lo_nxt;
  sector_t           sec_nxt;

  always_comb begin
    if (red >= green && red >= blue) begin
      sec_nxt = SEC_RED;
      hi_nxt  = red;
    end else if (green >= blue) begin
      sec_nxt = SEC_GREEN;
      hi_nxt  = green;
    end else begin
      sec_nxt = SEC_BLUE;
      hi_nxt  = blue;
    end
    lo_nxt = red;
    if (green < lo_nxt) lo_nxt = green;
    if (blue < lo_nxt) lo_nxt = blue;
  end

  // Stage 2: delta, hue numerator and the integer bit of saturation.
  logic              v2_r;
  logic              rdy2;
  div_state_t        st2_r, st2_nxt;
  logic              sint2_r, sint2_nxt;
  logic [CHAN_W-1:0] dl;
  logic [SPAN_W-1:0] span;
  logic signed [SPAN_W:0] num;
  logic [SPAN_W:0]   num_wrap;

  always_comb begin
    dl   = hi1_r - lo1_r;
    span = {1'b0, dl, 2'b00} + {2'b00, dl, 1'b0};
    case (sec1_r)
      SEC_RED:   num = $signed({4'b0, g1_r}) - $signed({4'b0, b1_r});
      SEC_GREEN: num = $signed({3'b0, dl, 1'b0}) + $signed({4'b0, b1_r})
                       - $signed({4'b0, r1_r});
      SEC_BLUE:  num = $signed({2'b0, dl, 2'b0}) + $signed({4'b0, r1_r})
                       - $signed({4'b0, g1_r});
      default:   num = '0;
    endcase
    // A negative numerator wraps by one full turn.
    if (num[SPAN_W]) num_wrap = $unsigned(num) + {1'b0, span};
    else num_wrap = $unsigned(num);

    st2_nxt.bright = hi1_r;
    // Black pixels get a unit saturation divisor, and black and grey pixels a unit hue
    // divisor, with zero remainders so that every quotient bit comes out zero.
    st2_nxt.hi_div = (hi1_r == '0) ? CHAN_W'(1) : hi1_r;
    if (dl == '0) begin
      st2_nxt.span = SPAN_W'(1);
      st2_nxt.hrem = '0;
    end else begin
      st2_nxt.span = span;
      st2_nxt.hrem = num_wrap[SPAN_W-1:0];
    end
    sint2_nxt = (dl >= st2_nxt.hi_div);
    st2_nxt.srem = sint2_nxt ? (dl - st2_nxt.hi_div) : dl;
  end

  assign rdy2     = !v2_r || o_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign o_valid  = v2_r;
  assign o_state  = st2_r;
  assign o_sat_int = sint2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      r1_r   <= red;
      g1_r   <= green;
      b1_r   <= blue;
      hi1_r  <= hi_nxt;
      lo1_r  <= lo_nxt;
      sec1_r <= sec_nxt;
    end
    if (rdy2 && v1_r) begin
      st2_r   <= st2_nxt;
      sint2_r <= sint2_nxt;
    end
  end

endmodule

### hdl/rgbhsv_div_step.sv
module rgbhsv_div_step #(
  parameter int FRAC_BITS = rgbhsv_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       i_valid,
  output logic                       i_ready,
  input  rgbhsv_pkg::div_state_t     i_state,
  input  logic [FRAC_BITS:0]         i_sat_q,
  input  logic [FRAC_BITS-1:0]       i_hue_q,
  output logic                       o_valid,
  input  logic                       o_ready,
  output rgbhsv_pkg::div_state_t     o_state,
  output logic [FRAC_BITS:0]         o_sat_q,
  output logic [FRAC_BITS-1:0]       o_hue_q
);
  import rgbhsv_pkg::*;

  // One restoring step of both dividers: one quotient bit each.
  logic                 valid_r;
  div_state_t           state_r, state_nxt;
  logic [FRAC_BITS:0]   sat_q_r, sat_q_nxt;
  logic [FRAC_BITS-1:0] hue_q_r, hue_q_nxt;
  logic [CHAN_W:0]      s2;
  logic [SPAN_W:0]      h2;
  logic                 sbit, hbit;

  always_comb begin
    s2   = {i_state.srem, 1'b0};
    h2   = {i_state.hrem, 1'b0};
    sbit = (s2 >= {1'b0, i_state.hi_div});
    hbit = (h2 >= {1'b0, i_state.span});
    state_nxt = i_state;
    if (sbit) state_nxt.srem = CHAN_W'(s2 - {1'b0, i_state.hi_div});
    else state_nxt.srem = s2[CHAN_W-1:0];
    if (hbit) state_nxt.hrem = SPAN_W'(h2 - {1'b0, i_state.span});
    else state_nxt.hrem = h2[SPAN_W-1:0];
    sat_q_nxt = {i_sat_q[FRAC_BITS-1:0], sbit};
    hue_q_nxt = {i_hue_q[FRAC_BITS-2:0], hbit};
  end

  assign i_ready = !valid_r || o_ready;
  assign o_valid = valid_r;
  assign o_state = state_r;
  assign o_sat_q = sat_q_r;
  assign o_hue_q = hue_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (i_ready) valid_r <= i_valid;
  end

  always_ff @(posedge clk) begin
    if (i_ready && i_valid) begin
      state_r <= state_nxt;
      sat_q_r <= sat_q_nxt;
      hue_q_r <= hue_q_nxt;
    end
  end

endmodule

### hdl/rgb_to_hsv_converter.sv
// Each word passes the registered front stages and divider steps; a stalled
// output holds it. Throughput: one word per cycle unless out_tready stalls,
// set by the pipelined long dividers that produce one quotient bit per stage
// for saturation and hue in parallel.
// Reset (rst_n low, synchronous) empties every stage; no output is pending.
module rgb_to_hsv_converter #(
  parameter int FRAC_BITS = rgbhsv_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [rgbhsv_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // hue [FRAC_BITS-1:0], saturation [2*FRAC_BITS:FRAC_BITS],
  // brightness next 8 bits, zero fill up to the byte boundary
  output logic [((2*FRAC_BITS+9+7)/8)*8-1:0]    out_tdata
);
  import rgbhsv_pkg::*;

  localparam int FIELD_W = 2 * FRAC_BITS + CHAN_W + 1;
  localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;
  localparam int PAD_W   = DATA_W - FIELD_W;

  logic                 valid_s [FRAC_BITS+1];
  logic                 ready_s [FRAC_BITS+1];
  div_state_t           state_s [FRAC_BITS+1];
  logic [FRAC_BITS:0]   sat_q_s [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] hue_q_s [FRAC_BITS+1];
  logic                 sat_int;

  rgbhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .red       (in_tdata[CHAN_W-1:0]),
    .green     (in_tdata[2*CHAN_W-1:CHAN_W]),
    .blue      (in_tdata[3*CHAN_W-1:2*CHAN_W]),
    .o_valid   (valid_s[0]),
    .o_ready   (ready_s[0]),
    .o_state   (state_s[0]),
    .o_sat_int (sat_int)
  );

  assign sat_q_s[0] = {{FRAC_BITS{1'b0}}, sat_int};
  assign hue_q_s[0] = '0;

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
    rgbhsv_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (valid_s[k]),
      .i_ready (ready_s[k]),
      .i_state (state_s[k]),
      .i_sat_q (sat_q_s[k]),
      .i_hue_q (hue_q_s[k]),
      .o_valid (valid_s[k+1]),
      .o_ready (ready_s[k+1]),
      .o_state (state_s[k+1]),
      .o_sat_q (sat_q_s[k+1]),
      .o_hue_q (hue_q_s[k+1])
    );
  end

  assign ready_s[FRAC_BITS] = out_tready;
  assign out_tvalid = valid_s[FRAC_BITS];
  assign out_tdata  = {{PAD_W{1'b0}}, state_s[FRAC_BITS].bright,
                       sat_q_s[FRAC_BITS], hue_q_s[FRAC_BITS]};

endmodule

### hdl/rgbhsv_checker.sv
`include "rgb_to_hsv_converter_defines.svh"

module rgbhsv_checker #(
  parameter int FRAC_BITS = rgbhsv_pkg::FRAC_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [rgbhsv_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*FRAC_BITS+9+7)/8)*8-1:0]   out_tdata
);
  import rgbhsv_pkg::*;

  localparam int SAT_LO = FRAC_BITS;
  localparam int SAT_HI = 2 * FRAC_BITS;
  localparam int BR_LO  = 2 * FRAC_BITS + 1;
  localparam int BR_HI  = 2 * FRAC_BITS + CHAN_W;

  logic in_seen;
  assign in_seen = in_tvalid && (in_tdata == in_tdata);

  // Reset empties the pipeline.
  `RGBHSV_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

  // A stalled output word holds.
  `RGBHSV_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
                 "stalled output word changed")

  // With nothing waiting at the output every stage can move.
  `RGBHSV_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready || !in_seen,
                 "input stalled while output is empty")

  // A black pixel has zero saturation and zero hue.
  `RGBHSV_ASSERT(a_black_pixel,
                 out_tvalid && out_tdata[BR_HI:BR_LO] == '0 |->
                 out_tdata[SAT_HI:SAT_LO] == '0 && out_tdata[FRAC_BITS-1:0] == '0,
                 "black pixel with nonzero hue or saturation")

endmodule

bind rgb_to_hsv_converter rgbhsv_checker #(.FRAC_BITS(FRAC_BITS)) u_rgbhsv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import rgbhsv_pkg::*;

  localparam int FB    = FRAC_BITS_DEF;
  localparam int OUT_W = ((2*FB+9+7)/8)*8;
  localparam int LAT   = FB + 2;

  typedef struct packed {
    logic [FB-1:0]     hue;
    logic [FB:0]       sat;
    logic [CHAN_W-1:0] bright;
  } hsv_t;

  // Keeps the HSV values the converter owes us, oldest first.
  class hsv_scoreboard;
    hsv_t owed_hsv[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    function hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      hsv_t              e;
      logic [7:0]        hi;
      logic [7:0]        lo;
      logic [7:0]        dl;
      int                num;
      longint unsigned   span;
      longint unsigned   q;
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      dl = hi - lo;
      e.hue = '0;
      e.sat = '0;
      e.bright = hi;
      if (hi != 0) begin
        q = (longint'(dl) << FB) / longint'(hi);
        e.sat = q[FB:0];
        if (dl != 0) begin
          span = 6 * longint'(dl);
          // Red wins ties over green, green over blue.
          if (r == hi) begin
            num = int'(g) - int'(b);
          end else if (g == hi) begin
            num = 2 * int'(dl) + int'(b) - int'(r);
          end else begin
            num = 4 * int'(dl) + int'(r) - int'(g);
          end
          if (num < 0) num += int'(span);
          q = (longint'(num) << FB) / span;
          e.hue = q[FB-1:0];
        end
      end
      return e;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      owed_hsv.push_back(convert_pixel(r, g, b));
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      hsv_t got;
      hsv_t exp_hsv;
      got.hue    = word[FB-1:0];
      got.sat    = word[2*FB:FB];
      got.bright = word[2*FB+8:2*FB+1];
      if (owed_hsv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected hsv word: hue %0d sat %0d bright %0d",
                   got.hue, got.sat, got.bright);
        return;
      end
      exp_hsv = owed_hsv.pop_front();
      if (got.hue !== exp_hsv.hue || got.sat !== exp_hsv.sat ||
          got.bright !== exp_hsv.bright) begin
        mismatches++;
        if (mismatches <= 10)
          $display("hsv word wrong: expected hue %0d sat %0d bright %0d, got hue %0d sat %0d bright %0d",
                   exp_hsv.hue, exp_hsv.sat, exp_hsv.bright,
                   got.hue, got.sat, got.bright);
      end
    endfunction

    function int outstanding();
      return owed_hsv.size();
    endfunction
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [23:0]      in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_asks    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  hsv_scoreboard sb = new();

  rgb_to_hsv_converter #(
    .FRAC_BITS(FB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("rgb_to_hsv_converter: mismatch");
    $finish;
  end

  // Result side: check every accepted word, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen  <= hold_asks;
      hold_left  <= 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Leaves valid high after a transfer so back-to-back words need no toggle.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(r, g, b);
  endtask

  function automatic logic [7:0] pick_channel();
    logic [7:0] v;
    case ($urandom_range(9))
      0: v = 8'd0;
      1: v = 8'd255;
      2: v = 8'($urandom_range(3));
      3: v = 8'(255 - $urandom_range(3));
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  // Mostly random channels, with ties and greys mixed in often.
  task automatic send_random_pixels(input int count);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      r = pick_channel();
      g = pick_channel();
      b = pick_channel();
      case ($urandom_range(7))
        0: g = r;
        1: b = r;
        2: b = g;
        3: begin
          g = r;
          b = r;
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    // Red on top with blue above green gives a negative hue that wraps.
    send_pixel(8'd255, 8'd0, 8'd10);
    send_pixel(8'd255, 8'd0, 8'd254);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd10, 8'd200, 8'd30);
    send_pixel(8'd200, 8'd10, 8'd250);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd255, 8'd1, 8'd1);

    send_random_pixels(160);

    tx_idle_pct = 85;
    send_random_pixels(150);
    tx_idle_pct = 0;
    rx_stall_pct = 85;
    send_random_pixels(150);
    tx_idle_pct = 27;
    rx_stall_pct = 27;
    send_random_pixels(150);

    // Long receiver hold-off while words keep coming, so the pipe backs up.
    wait_drained();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_asks = hold_asks + 1;
    send_random_pixels(80);
    wait_drained();

    tx_idle_pct = 10;
    rx_stall_pct = 10;
    send_random_pixels(60);

    wait_drained();
    repeat (LAT + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("rgb_to_hsv_converter: match");
    end else begin
      $display("rgb_to_hsv_converter: mismatch");
    end
    $finish;
  end

endmodule
